// ===== hw/rtl/point_in_polygon_test_unit_macros.svh =====
// assertion macros for the point in polygon test unit checker
// depends on: nothing; expects clock and reset signals in the using scope
`ifndef POINT_IN_POLYGON_TEST_UNIT_MACROS_SVH
`define POINT_IN_POLYGON_TEST_UNIT_MACROS_SVH

// same-cycle implication
`define PIP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PIP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/pip_pkg.sv =====
// shared types and constants for the point in polygon test unit
// depends on: nothing
package pip_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int COORD_WIDTH  = 32;
   localparam int VIDX_WIDTH   = $clog2(MAX_VERTICES);
   localparam int COUNT_WIDTH  = $clog2(MAX_VERTICES + 1);
   localparam int DIFF_WIDTH   = COORD_WIDTH + 1;
   localparam int PROD_WIDTH   = 2 * DIFF_WIDTH;

   localparam int CFG_COUNT_WIDTH = 7;
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam logic [CFG_COUNT_WIDTH-1:0] VERTEX_COUNT_RESET = CFG_COUNT_WIDTH'(3);

   // register index taken from the word address
   localparam logic REG_VERTEX_COUNT = 1'b0;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TEST  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN
   } pip_state_type;

endpackage

// ===== hw/rtl/point_in_polygon_test_unit.sv =====
// point in polygon test unit: even-odd ray casting, one edge per cycle; depends on pip_pkg
// from start transaction to result strobe (n = vertex_count capped at MAX_VERTICES):
// n + 1 store reads, three-stage edge unit, drain check and result register
// a new test or vertex write is taken only while busy is low; a count of zero skips the
// walk; a vertex write leaves the unit idle with no result, and the receiver cannot stall
// reset sets vertex_count to 3 and idles the sequencer; the vertex store is not cleared
module point_in_polygon_test_unit
   import pip_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_opcode,
   input  logic [VIDX_WIDTH-1:0]         req_vertex_index,
   input  logic signed [COORD_WIDTH-1:0] req_coord_x,
   input  logic signed [COORD_WIDTH-1:0] req_coord_y,
   output logic                          rsp_valid,
   output logic                          rsp_inside_res,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]     paddr,
   input  logic [CSR_DATA_WIDTH-1:0]     pwdata,
   output logic [CSR_DATA_WIDTH-1:0]     prdata,
   output logic                          pready
);

   logic signed [COORD_WIDTH-1:0] vertex_x_mem [MAX_VERTICES];
   logic signed [COORD_WIDTH-1:0] vertex_y_mem [MAX_VERTICES];

   pip_state_type state_ff, state_in;
   logic [CFG_COUNT_WIDTH-1:0] vertex_count_ff;
   logic [COUNT_WIDTH-1:0] n_ff, n_sat;
   logic [COUNT_WIDTH-1:0] rd_cnt_ff, rd_cnt_in;
   logic [VIDX_WIDTH-1:0] rd_addr;
   logic rd_en, finish, accept, test_accept, write_accept, csr_write;

   logic signed [COORD_WIDTH-1:0] pt_x_ff, pt_y_ff;
   logic signed [COORD_WIDTH-1:0] rd_x_ff, rd_y_ff, prev_x_ff, prev_y_ff;
   logic rd_vld_ff, rd_first_ff;

   // edge unit stage b
   logic b_vld_ff, b_range_ff;
   logic signed [DIFF_WIDTH-1:0] b_a_ff, b_d_ff, b_b_ff, b_c_ff;
   logic range_ok;
   logic signed [COORD_WIDTH-1:0] ymin, ymax, xmax;
   logic signed [DIFF_WIDTH-1:0] diff_a, diff_c, diff_num, diff_den;
   logic signed [DIFF_WIDTH-1:0] num_pos, den_pos;

   // edge unit stage c
   logic c_vld_ff, c_range_ff;
   logic signed [PROD_WIDTH-1:0] c_p_ff, c_q_ff;

   logic inside_ff, inside_in;
   logic rsp_valid_ff, rsp_inside_ff;

   assign accept       = start && !busy;
   assign test_accept  = accept && (req_opcode == OP_TEST);
   assign write_accept = accept && (req_opcode == OP_WRITE)
                         && (int'(req_vertex_index) < MAX_VERTICES);
   assign busy         = (state_ff != ST_IDLE);

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready
                      && (paddr[CSR_ADDR_WIDTH-1] == REG_VERTEX_COUNT);
   assign prdata    = (paddr[CSR_ADDR_WIDTH-1] == REG_VERTEX_COUNT)
                      ? CSR_DATA_WIDTH'(vertex_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VERTEX_COUNT_RESET;
      end else if (csr_write) begin
         vertex_count_ff <= pwdata[CFG_COUNT_WIDTH-1:0];
      end
   end

   assign n_sat = (int'(vertex_count_ff) > MAX_VERTICES)
                  ? COUNT_WIDTH'(MAX_VERTICES) : COUNT_WIDTH'(vertex_count_ff);

   // walk addresses 0..n-1 then vertex zero again to close the polygon
   assign rd_addr = (rd_cnt_ff == n_ff) ? '0 : rd_cnt_ff[VIDX_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (write_accept) begin
         vertex_x_mem[req_vertex_index] <= req_coord_x;
         vertex_y_mem[req_vertex_index] <= req_coord_y;
      end
      if (rd_en) begin
         rd_x_ff <= vertex_x_mem[rd_addr];
         rd_y_ff <= vertex_y_mem[rd_addr];
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      rd_cnt_in = rd_cnt_ff;
      rd_en     = 1'b0;
      finish    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (test_accept) begin
               rd_cnt_in = '0;
               state_in  = (n_sat == '0) ? ST_DRAIN : ST_WALK;
            end
         end
         ST_WALK: begin
            rd_en     = 1'b1;
            rd_cnt_in = rd_cnt_ff + COUNT_WIDTH'(1);
            if (rd_cnt_ff == n_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !b_vld_ff && !c_vld_ff) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_en;
         b_vld_ff     <= rd_vld_ff && !rd_first_ff;
         c_vld_ff     <= b_vld_ff;
         rsp_valid_ff <= finish;
      end
   end

   always_ff @(posedge clock) begin
      rd_cnt_ff <= rd_cnt_in;
      if (test_accept) begin
         n_ff    <= n_sat;
         pt_x_ff <= req_coord_x;
         pt_y_ff <= req_coord_y;
      end
      if (rd_en) begin
         rd_first_ff <= (rd_cnt_ff == '0);
      end
      if (rd_vld_ff) begin
         prev_x_ff <= rd_x_ff;
         prev_y_ff <= rd_y_ff;
      end
   end

   // stage b: bounds test and differences, divisor made positive
   always_comb begin
      ymin     = (prev_y_ff < rd_y_ff) ? prev_y_ff : rd_y_ff;
      ymax     = (prev_y_ff < rd_y_ff) ? rd_y_ff : prev_y_ff;
      xmax     = (prev_x_ff < rd_x_ff) ? rd_x_ff : prev_x_ff;
      range_ok = (pt_y_ff > ymin) && (pt_y_ff <= ymax) && (pt_x_ff <= xmax);
      diff_a   = {pt_x_ff[COORD_WIDTH-1], pt_x_ff} - {prev_x_ff[COORD_WIDTH-1], prev_x_ff};
      diff_c   = {rd_x_ff[COORD_WIDTH-1], rd_x_ff} - {prev_x_ff[COORD_WIDTH-1], prev_x_ff};
      diff_num = {pt_y_ff[COORD_WIDTH-1], pt_y_ff} - {prev_y_ff[COORD_WIDTH-1], prev_y_ff};
      diff_den = {rd_y_ff[COORD_WIDTH-1], rd_y_ff} - {prev_y_ff[COORD_WIDTH-1], prev_y_ff};
      if (diff_den < 0) begin
         num_pos = -diff_num;
         den_pos = -diff_den;
      end else begin
         num_pos = diff_num;
         den_pos = diff_den;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         b_range_ff <= range_ok;
         b_a_ff     <= diff_a;
         b_d_ff     <= den_pos;
         b_b_ff     <= num_pos;
         b_c_ff     <= diff_c;
      end
      // stage c: the two cross products
      if (b_vld_ff) begin
         c_range_ff <= b_range_ff;
         c_p_ff     <= PROD_WIDTH'(b_a_ff) * PROD_WIDTH'(b_d_ff);
         c_q_ff     <= PROD_WIDTH'(b_b_ff) * PROD_WIDTH'(b_c_ff);
      end
   end

   // stage d: crossing test toggles the parity flag
   always_comb begin
      inside_in = inside_ff;
      if (test_accept) begin
         inside_in = 1'b0;
      end else if (c_vld_ff && c_range_ff && (c_p_ff <= c_q_ff)) begin
         inside_in = !inside_ff;
      end
   end

   always_ff @(posedge clock) begin
      inside_ff <= inside_in;
      if (finish) begin
         rsp_inside_ff <= inside_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;

endmodule

// ===== hw/rtl/pip_checker.sv =====
// port-level checker for the point in polygon test unit, bound to the top level
// depends on: pip_pkg, point_in_polygon_test_unit_macros.svh
`include "point_in_polygon_test_unit_macros.svh"

module pip_checker
   import pip_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_opcode,
   input logic rsp_valid
);

   // a result strobe lasts one cycle and tests never finish back to back
   `PIP_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid, "result strobe longer than one cycle")

   // an accepted test makes the unit busy
   `PIP_ASSERT_NEXT(a_test_busy, start && !busy && (req_opcode == OP_TEST), busy, "test not started")

   // a vertex write completes at once with no result
   `PIP_ASSERT_NEXT(a_write_quiet, start && !busy && (req_opcode == OP_WRITE), !busy && !rsp_valid, "vertex write made the unit busy or gave a result")

   // busy drops exactly when the result appears
   `PIP_ASSERT_SAME(a_done_rsp, !$past(reset) && $fell(busy), rsp_valid, "test ended without a result")

endmodule

bind point_in_polygon_test_unit pip_checker u_pip_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_opcode (req_opcode),
   .rsp_valid  (rsp_valid)
);
